[rtl/dce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_pkg: shared definitions for the dyadic convolution engine
// Sizes, widths, the controller command and status types and the run length.
// ----------------------------------------------------------------------------
package dce_pkg;

    localparam int MAX_SIZE = 16;
    localparam int DATA_W   = 16;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int SIZE_W   = 3;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = 36;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] LOG2_MAX   = SIZE_W'(ADDR_W);

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              acc_clear;
        logic              out_load;
        logic [ADDR_W-1:0] out_index;
        logic              out_last;
    } dce_cmd_t;

    typedef struct packed {
        logic busy;
    } dce_status_t;

    function automatic logic [CNT_W-1:0] run_length(input logic [SIZE_W-1:0] lg);
        logic [SIZE_W-1:0] l;
        l = (lg > LOG2_MAX) ? LOG2_MAX : lg;
        return CNT_W'(1) << l;
    endfunction

endpackage

[rtl/dce_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_datapath: operand stores and multiply-accumulate pipeline
// Holds the loaded rows, reads one operand pair a cycle, multiplies,
// accumulates, and keeps the result register for the output channel.
// ----------------------------------------------------------------------------
module dce_datapath
    import dce_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dce_cmd_t                 cmd,
    output dce_status_t              status,
    input  logic signed [DATA_W-1:0] a_value,
    input  logic signed [DATA_W-1:0] b_value,
    output logic signed [ACC_W-1:0]  c_value,
    output logic [ADDR_W-1:0]        c_index,
    output logic                     last_result
);

    logic signed [DATA_W-1:0] a_store_reg [MAX_SIZE];
    logic signed [DATA_W-1:0] b_store_reg [MAX_SIZE];
    logic signed [DATA_W-1:0] a_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     rd_valid_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  c_value_reg;
    logic [ADDR_W-1:0]        c_index_reg;
    logic                     last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            a_store_reg[cmd.wr_addr] <= a_value;
            b_store_reg[cmd.wr_addr] <= b_value;
        end
        a_rd_reg <= a_store_reg[cmd.rd_a_addr];
        b_rd_reg <= b_store_reg[cmd.rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_rd_reg * b_rd_reg;
        acc_reg  <= acc_next;
        if (cmd.out_load)
        begin
            c_value_reg <= acc_reg;
            c_index_reg <= cmd.out_index;
            last_reg    <= cmd.out_last;
        end
    end

    assign status.busy  = rd_valid_reg | prod_valid_reg;
    assign c_value      = c_value_reg;
    assign c_index      = c_index_reg;
    assign last_result  = last_reg;

endmodule

[rtl/dce_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_controller: load and compute sequencer
// Counts loaded pairs, steps the index pair over the operand stores for
// each result and hands results to the output channel.
// ----------------------------------------------------------------------------
module dce_controller
    import dce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] size_log2,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output dce_cmd_t          cmd,
    input  dce_status_t       status
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  count_inc;
    logic [ADDR_W-1:0] mask;

    assign len       = run_length(size_log2);
    assign mask      = ADDR_W'(len - CNT_W'(1));
    assign count_inc = load_count_reg + CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        in_stall        = 1'b1;
        out_valid       = 1'b0;
        cmd             = '0;
        cmd.wr_addr     = load_count_reg[ADDR_W-1:0];
        cmd.rd_a_addr   = i_reg;
        cmd.rd_b_addr   = (i_reg ^ k_reg) & mask;
        cmd.out_index   = k_reg;
        cmd.out_last    = (k_reg == mask);
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.wr_en = 1'b1;
                    if (count_inc >= len)
                    begin
                        load_count_next = '0;
                        i_next          = '0;
                        k_next          = '0;
                        cmd.acc_clear   = 1'b1;
                        state_next      = ST_MAC;
                    end
                    else
                    begin
                        load_count_next = count_inc;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (i_reg == mask)
                begin
                    i_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (k_reg == mask)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next        = k_reg + ADDR_W'(1);
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg < CNT_W'(MAX_SIZE))
        else $error("Load count reached the store depth.");

    a_emit_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !status.busy)
        else $error("Result shown while products are still in flight.");

    a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && cmd.out_last) |=> (state_reg == ST_LOAD))
        else $error("Run did not end after the last result.");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (status.busy || out_valid) |-> in_stall)
        else $error("Input accepted during computation.");

endmodule

[rtl/dyadic_convolution_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dyadic_convolution_engine_top: dyadic (XOR) convolution of two rows
// Loads 2^size_log2 operand pairs (size_log2 saturates at 4), then emits c[k] = sum a[i]*b[i xor k].
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   a_value, b_value
//   out       output     out_valid / out_stall c_value, c_index, last_result
//   cfg       input      cfg_we                cfg_wdata (size_log2)
//
// Input transactions are accepted while loading.
// Each result is issued on the shared multiply-accumulate unit, which then drains,
// and is then shown on the output; the next result starts only after the current
// one has been taken from the output.
// Reset clears the controller and sets size_log2 to 4; stores need no clear.
// Input is stalled during computation; an output stall holds the result.
// ----------------------------------------------------------------------------
module dyadic_convolution_engine_top
    import dce_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [SIZE_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] a_value,
    input  logic signed [DATA_W-1:0] b_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [ACC_W-1:0]  c_value,
    output logic [ADDR_W-1:0]        c_index,
    output logic                     last_result
);

    logic [SIZE_W-1:0] size_reg;
    dce_cmd_t          cmd;
    dce_status_t       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    dce_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_log2 (size_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    dce_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .a_value     (a_value),
        .b_value     (b_value),
        .c_value     (c_value),
        .c_index     (c_index),
        .last_result (last_result)
    );

endmodule

[dv/tb_dyadic_convolution_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dyadic_convolution_engine_top: self-checking bench for the XOR convolver
// Loads operand rows at several run lengths, predicts every convolution
// result with a scoreboard and compares each output transaction field by
// field. Includes saturated and zero sizes and a size change inside a run.
// The sender works in bursts, the receiver stalls at random, and one long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_dyadic_convolution_engine_top;
    import dce_pkg::*;

    typedef struct packed {
        logic [ACC_W-1:0]  value;
        logic [ADDR_W-1:0] index;
        logic              last;
    } conv_result_t;

    class conv_scoreboard;
        logic [SIZE_W-1:0]        size_log2;
        logic signed [DATA_W-1:0] a_row [MAX_SIZE];
        logic signed [DATA_W-1:0] b_row [MAX_SIZE];
        int                       loaded;
        conv_result_t             pending_q [$];
        int                       mismatches;

        function new();
            size_log2  = SIZE_RESET;
            loaded     = 0;
            mismatches = 0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_log2 = v;
        endfunction

        function void note_input(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
            int           len;
            int           lg;
            longint       acc;
            conv_result_t r;
            lg  = (size_log2 > ADDR_W) ? ADDR_W : int'(size_log2);
            len = 1 << lg;
            if (loaded < MAX_SIZE)
            begin
                a_row[loaded] = a;
                b_row[loaded] = b;
            end
            loaded++;
            if (loaded >= len)
            begin
                for (int k = 0; k < len; k++)
                begin
                    acc = 0;
                    for (int i = 0; i < len; i++)
                    begin
                        acc += longint'(a_row[i]) * longint'(b_row[(i ^ k) & (len - 1)]);
                    end
                    r.value = acc[ACC_W-1:0];
                    r.index = k[ADDR_W-1:0];
                    r.last  = (k == len - 1);
                    pending_q.push_back(r);
                end
                loaded = 0;
            end
        endfunction

        function void report(string what, conv_result_t e, conv_result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: expected value=%0d index=%0d last=%0b, got value=%0d index=%0d last=%0b",
                         what, $signed(e.value), e.index, e.last,
                         $signed(got.value), got.index, got.last);
            end
        endfunction

        function void check_result(logic [ACC_W-1:0] v, logic [ADDR_W-1:0] idx, logic last);
            conv_result_t e;
            conv_result_t got;
            got.value = v;
            got.index = idx;
            got.last  = last;
            if (pending_q.size() == 0)
            begin
                e = '0;
                report("unexpected result", e, got);
            end
            else
            begin
                e = pending_q.pop_front();
                if (e !== got)
                begin
                    report("result mismatch", e, got);
                end
            end
        endfunction

        function void check_drained();
            conv_result_t none;
            none = '0;
            while (pending_q.size() > 0)
            begin
                report("missing result", pending_q.pop_front(), none);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [SIZE_W-1:0]        cfg_wdata;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [ACC_W-1:0]  c_value;
    logic [ADDR_W-1:0]        c_index;
    logic                     last_result;

    conv_scoreboard sb = new();
    int             burst_left;
    int             items_sent;
    bit             hold_req;

    localparam logic signed [DATA_W-1:0] EXT_A [8] = '{
        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000,
        16'shFFFF, 16'sh0001, 16'sh7FFF, 16'shFFFF};
    localparam logic signed [DATA_W-1:0] EXT_B [8] = '{
        16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'shFFFF,
        16'sh0000, 16'sh8000, 16'sh8000, 16'shFFFF};

    dyadic_convolution_engine_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_value     (a_value),
        .b_value     (b_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .c_value     (c_value),
        .c_index     (c_index),
        .last_result (last_result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int tmp;
        case ($urandom_range(0, 9))
            6, 7:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            8, 9:
            begin
                tmp = int'($urandom_range(0, 16)) - 8;
                return tmp[DATA_W-1:0];
            end
            default:
            begin
                tmp = int'($urandom_range(0, 65535));
                return tmp[DATA_W-1:0];
            end
        endcase
    endfunction

    task automatic send_pair(input logic signed [DATA_W-1:0] a,
                             input logic signed [DATA_W-1:0] b,
                             input bit more);
        int gap;
        in_valid <= 1'b1;
        a_value  <= a;
        b_value  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(a, b);
        items_sent++;
        if (!more)
        begin
            in_valid <= 1'b0;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        while (sb.pending_q.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_size(v);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int hold_left;
        int window;
        int stall_pct;
        bit hold_done;
        hold_left = 0;
        window    = 0;
        stall_pct = 0;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(c_value, c_index, last_result);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = 600;
            end
            if (window == 0)
            begin
                window = $urandom_range(16, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            window--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin
        int phase;
        int sz;
        int len;
        int runs;
        int partial;
        int mode;
        bit more;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        a_value    <= '0;
        b_value    <= '0;
        burst_left = 0;
        items_sent = 0;
        hold_req   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Partial run at the reset size, then a shorter size that the count already covers.
        for (int i = 0; i < 5; i++)
            send_pair(pick_operand(), pick_operand(), i < 4);
        wait_idle();
        write_size(3'd2);
        send_pair(pick_operand(), pick_operand(), 0);
        wait_idle();

        write_size(3'd0);
        send_pair(16'sh8000, 16'sh8000, 1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1);
        send_pair(16'sh8000, 16'sh7FFF, 0);
        wait_idle();

        write_size(3'd1);
        send_pair(16'sh7FFF, 16'sh8000, 1);
        send_pair(16'shFFFF, 16'shFFFF, 0);
        wait_idle();

        write_size(3'd3);
        for (int i = 0; i < 8; i++)
            send_pair(EXT_A[i], EXT_B[i], i < 7);
        wait_idle();

        phase = 0;
        while (items_sent < 230)
        begin
            sz   = (phase < 8) ? phase : int'($urandom_range(0, 7));
            len  = 1 << ((sz > ADDR_W) ? ADDR_W : sz);
            runs = (phase == 3) ? 3 : int'($urandom_range(1, 3));
            partial = (len > 1 && $urandom_range(0, 7) == 0) ? int'($urandom_range(1, len - 1)) : 0;
            write_size(sz[SIZE_W-1:0]);
            for (int r = 0; r < runs; r++)
            begin
                mode = $urandom_range(0, 7);
                if (phase == 3 && r == 1)
                    hold_req = 1;
                for (int i = 0; i < len; i++)
                begin
                    case (mode)
                        0:
                        begin
                            a = 16'sh8000;
                            b = 16'sh8000;
                        end
                        1:
                        begin
                            a = 16'sh8000;
                            b = 16'sh7FFF;
                        end
                        default:
                        begin
                            a = pick_operand();
                            b = pick_operand();
                        end
                    endcase
                    more = !(r == runs - 1 && i == len - 1 && partial == 0);
                    send_pair(a, b, more);
                end
            end
            for (int i = 0; i < partial; i++)
                send_pair(pick_operand(), pick_operand(), i < partial - 1);
            wait_idle();
            phase++;
        end

        sb.check_drained();
        if (sb.mismatches == 0)
        begin
            $display("PASS dyadic_convolution_engine_top");
        end
        else
        begin
            $display("FAIL dyadic_convolution_engine_top");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL dyadic_convolution_engine_top");
        $finish;
    end

endmodule

[sim.f]
rtl/dce_pkg.sv
rtl/dce_datapath.sv
rtl/dce_controller.sv
rtl/dyadic_convolution_engine_top.sv
dv/tb_dyadic_convolution_engine_top.sv
